[rtl/slpp_pkg.sv]
// Shared types and codes for the status and line packet parser.
package slpp_pkg;

  localparam int ByteW = 8;
  localparam int StatusW = 25;
  localparam logic [2:0] StatusLast = 3'd4;

  localparam logic [2:0] PH_TYPE = 3'd0;
  localparam logic [2:0] PH_STATUS = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_RHO = 3'd3;
  localparam logic [2:0] PH_THETA = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic CFG_STATUS_CODE = 1'b0;
  localparam logic CFG_FRAME_CODE = 1'b1;

  typedef struct packed {
    logic [1:0]       kind;
    logic             processing_on;
    logic [ByteW-1:0] segment_threshold;
    logic [ByteW-1:0] sigma_q6;
    logic [ByteW-1:0] edge_threshold;
    logic [ByteW-1:0] hough_threshold;
    logic [ByteW-1:0] rho_q1;
    logic [ByteW-1:0] theta_q6;
    logic [ByteW-1:0] line_number;
    logic             last_line;
  } result_t;

endpackage

[rtl/status_and_line_packet_parser.sv]
// Byte-stream parser for status and line-list packets, with result register.
// Takes one received byte per clock while the output side does not stall and
// gives at most one result per byte. A byte is registered on entry, parsed by the
// packet state machine and its result is written to the output register.
// Throughput is one byte per cycle whenever the output side does not stall; the
// output register stalls the input register, which stalls the input channel. The
// two type codes are written through the configuration port and apply from the
// next type byte.
module status_and_line_packet_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [slpp_pkg::ByteW-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [slpp_pkg::ByteW-1:0] rx_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               result_kind,
  output logic                     processing_on,
  output logic [slpp_pkg::ByteW-1:0] segment_threshold,
  output logic [slpp_pkg::ByteW-1:0] sigma_q6,
  output logic [slpp_pkg::ByteW-1:0] edge_threshold,
  output logic [slpp_pkg::ByteW-1:0] hough_threshold,
  output logic [slpp_pkg::ByteW-1:0] rho_q1,
  output logic [slpp_pkg::ByteW-1:0] theta_q6,
  output logic [slpp_pkg::ByteW-1:0] line_number,
  output logic                     last_line
);
  import slpp_pkg::*;

  logic [ByteW-1:0] status_code;
  logic [ByteW-1:0] frame_code;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             advance;

  logic [2:0]         phase, phase_next;
  logic [2:0]         field_count, field_count_next;
  logic [ByteW-1:0]   lines_left, lines_left_next;
  logic [ByteW-1:0]   line_count, line_count_next;
  logic [ByteW-1:0]   held_rho, held_rho_next;
  logic [StatusW-1:0] held_status, held_status_next;

  result_t res, res_next;
  logic    res_fire;

  assign cfg_ready = 1'b1;
  assign advance = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_code <= 8'd1;
      frame_code <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STATUS_CODE: status_code <= cfg_data;
        CFG_FRAME_CODE:  frame_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // Packet state machine.
  always_comb begin
    phase_next = phase;
    field_count_next = field_count;
    lines_left_next = lines_left;
    line_count_next = line_count;
    held_rho_next = held_rho;
    held_status_next = held_status;
    res_next = '0;
    res_fire = 1'b0;
    if (s1_valid && advance) begin
      case (phase)
        PH_STATUS: begin
          if (field_count == StatusLast) begin
            res_fire = 1'b1;
            res_next.kind = KIND_STATUS;
            res_next.processing_on = held_status[24];
            res_next.segment_threshold = held_status[23:16];
            res_next.sigma_q6 = held_status[15:8];
            res_next.edge_threshold = held_status[7:0];
            res_next.hough_threshold = s1_byte;
            phase_next = PH_TYPE;
            field_count_next = 3'd0;
          end else begin
            case (field_count)
              3'd0: held_status_next = {(s1_byte != '0), 24'd0};
              3'd1: held_status_next[23:16] = s1_byte;
              3'd2: held_status_next[15:8] = s1_byte;
              3'd3: held_status_next[7:0] = s1_byte;
              default: ;
            endcase
            field_count_next = field_count + 3'd1;
          end
        end
        PH_COUNT: begin
          if (s1_byte == '0) begin
            res_fire = 1'b1;
            res_next.kind = KIND_EMPTY;
            res_next.last_line = 1'b1;
            phase_next = PH_TYPE;
          end else begin
            lines_left_next = s1_byte;
            line_count_next = '0;
            phase_next = PH_RHO;
          end
        end
        PH_RHO: begin
          held_rho_next = s1_byte;
          phase_next = PH_THETA;
        end
        PH_THETA: begin
          res_fire = 1'b1;
          res_next.kind = KIND_LINE;
          res_next.rho_q1 = held_rho;
          res_next.theta_q6 = s1_byte;
          res_next.line_number = line_count;
          res_next.last_line = (lines_left <= 8'd1);
          lines_left_next = lines_left - 8'd1;
          line_count_next = line_count + 8'd1;
          phase_next = (lines_left_next == '0) ? PH_TYPE : PH_RHO;
        end
        default: begin
          if (s1_byte == status_code) begin
            phase_next = PH_STATUS;
            field_count_next = 3'd0;
          end else if (s1_byte == frame_code) begin
            phase_next = PH_COUNT;
          end else begin
            res_fire = 1'b1;
            res_next.kind = KIND_UNKNOWN;
            phase_next = PH_TYPE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      field_count <= '0;
      lines_left <= '0;
      line_count <= '0;
      held_rho <= '0;
      held_status <= '0;
    end else begin
      phase <= phase_next;
      field_count <= field_count_next;
      lines_left <= lines_left_next;
      line_count <= line_count_next;
      held_rho <= held_rho_next;
      held_status <= held_status_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result_kind = res.kind;
  assign processing_on = res.processing_on;
  assign segment_threshold = res.segment_threshold;
  assign sigma_q6 = res.sigma_q6;
  assign edge_threshold = res.edge_threshold;
  assign hough_threshold = res.hough_threshold;
  assign rho_q1 = res.rho_q1;
  assign theta_q6 = res.theta_q6;
  assign line_number = res.line_number;
  assign last_line = res.last_line;

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_STATUS |-> field_count <= StatusLast)
    else $error("status field count out of range");

  a_lines_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TYPE || phase == PH_STATUS || phase == PH_COUNT) |-> lines_left == '0)
    else $error("lines left outside of a line list");

  a_lines_busy: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RHO || phase == PH_THETA) |-> lines_left != '0)
    else $error("line list phase with no lines left");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_EMPTY |-> last_line && line_number == '0)
    else $error("empty frame result malformed");

  a_unknown_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_UNKNOWN |-> !last_line && !processing_on &&
      rho_q1 == '0 && theta_q6 == '0 && hough_threshold == '0)
    else $error("unknown type result carries payload");

endmodule
